>>> design/pdh_pkg.sv
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared types and constants for the pair distance histogram block.
// ----------------------------------------------------------------------------
package pdh_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_FRAME = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_BOX_X    = 3'd0;
    localparam logic [2:0] CFG_BOX_Y    = 3'd1;
    localparam logic [2:0] CFG_BOX_Z    = 3'd2;
    localparam logic [2:0] CFG_INV_BW   = 3'd3;
    localparam logic [2:0] CFG_NUM_BINS = 3'd4;
    localparam logic [2:0] CFG_NUM_SPEC = 3'd5;

    // datapath widths
    localparam int POS_W      = 24;
    localparam int BOX_W      = 23;
    localparam int IBW_W      = 24;
    localparam int DIFF_W     = 26;
    localparam int MAG_W      = 24;
    localparam int SQ_W       = 48;
    localparam int R2_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int REM_W      = 27;
    localparam int PROD_W     = 49;
    localparam int FRAC_W     = 16;
    localparam int BIN_W      = 33;
    localparam int CNT_W      = 32;
    localparam int STEP_W     = 5;
    localparam int SQ_STEPS   = 3;
    localparam int ROOT_STEPS = 25;

    localparam logic [CNT_W-1:0] SAT32 = '1;

    typedef struct packed {
        logic [BOX_W-1:0] box_len_x;
        logic [BOX_W-1:0] box_len_y;
        logic [BOX_W-1:0] box_len_z;
        logic [IBW_W-1:0] inv_bin_width;
        logic [8:0]       num_bins;
        logic [2:0]       num_species;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        op_t        op;
        logic       ok;
        logic [7:0] bin_index;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIFF,
        F_SQ,
        F_ROOT,
        F_SCALE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ
    } back_state_t;

endpackage

>>> design/pdh_fifo.sv
// ----------------------------------------------------------------------------
// pdh_fifo
// Two-entry queue between the classifying front and the histogram back.
// ----------------------------------------------------------------------------
module pdh_fifo #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    // handshake flags
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> design/pdh_front.sv
// ----------------------------------------------------------------------------
// pdh_front
// Accepts items, computes minimum-image distance, integer root and bin,
// and classifies each item into a command and histogram address.
// ----------------------------------------------------------------------------
module pdh_front #(
    parameter int MAX_SPECIES = 4,
    parameter int MAX_BINS    = 256,
    parameter int AW          = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pdh_pkg::cfg_t              cfg,
    input  logic                       hold,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pdh_pkg::op_t               s_op,
    input  logic signed [23:0]         s_xa,
    input  logic signed [23:0]         s_ya,
    input  logic signed [23:0]         s_za,
    input  logic signed [23:0]         s_xb,
    input  logic signed [23:0]         s_yb,
    input  logic signed [23:0]         s_zb,
    input  logic [1:0]                 s_type_a,
    input  logic [1:0]                 s_type_b,
    input  logic [7:0]                 s_read_bin,
    output logic                       q_valid,
    input  logic                       q_ready,
    output pdh_pkg::cmd_t              q_cmd,
    output logic [AW-1:0]              q_addr
);
    import pdh_pkg::*;

    localparam int SP_W  = 5;
    localparam int CMP_W = BIN_W + 1;
    localparam int BW    = $clog2(MAX_BINS);

    front_state_t             state_reg, state_next;
    op_t                      op_reg;
    logic signed [POS_W-1:0]  xa_reg, ya_reg, za_reg, xb_reg, yb_reg, zb_reg;
    logic [1:0]               ta_reg, tb_reg;
    logic [7:0]               rbin_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [SQ_W-1:0]          prod_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [BIN_W-1:0]         bin_reg;

    logic signed [DIFF_W-1:0] dsel, dneg;
    logic [MAG_W-1:0]         mag;
    logic [REM_W-1:0]         rem_shift, trial;
    logic [PROD_W-1:0]        scaled;
    logic [SP_W-1:0]          eff_s;
    logic [CMP_W-1:0]         eff_b, idx_wide;
    logic [1:0]               lo, hi;
    logic [7:0]               pair, tri_n;
    logic                     type_ok, bin_ok;

    function automatic logic signed [DIFF_W-1:0] min_img(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b,
        input logic [BOX_W-1:0]        len
    );
        logic signed [DIFF_W-1:0] d, l, d2;
        d  = DIFF_W'(a) - DIFF_W'(b);
        l  = $signed(DIFF_W'({1'b0, len}));
        d2 = d <<< 1;
        if (d2 > l) begin
            min_img = d - l;
        end else if (d2 < -l) begin
            min_img = d + l;
        end else begin
            min_img = d;
        end
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = (s_op == OP_ACC) ? F_DIFF : F_PUSH;
                end
            end
            F_DIFF:  state_next = F_SQ;
            F_SQ: begin
                if (step_reg == STEP_W'(SQ_STEPS)) begin
                    state_next = F_ROOT;
                end
            end
            F_ROOT: begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1)) begin
                    state_next = F_SCALE;
                end
            end
            F_SCALE: state_next = F_PUSH;
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == F_IDLE) && !hold;
        q_valid = (state_reg == F_PUSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // square of the selected axis and one root step
    always_comb begin
        case (step_reg)
            STEP_W'(0): dsel = dx_reg;
            STEP_W'(1): dsel = dy_reg;
            default:    dsel = dz_reg;
        endcase
        dneg      = -dsel;
        mag       = dsel[DIFF_W-1] ? dneg[MAG_W-1:0] : dsel[MAG_W-1:0];
        rem_shift = {rem_reg[REM_W-3:0], r2_reg[R2_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        scaled    = PROD_W'(root_reg) * PROD_W'(cfg.inv_bin_width);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    op_reg   <= s_op;
                    xa_reg   <= s_xa;
                    ya_reg   <= s_ya;
                    za_reg   <= s_za;
                    xb_reg   <= s_xb;
                    yb_reg   <= s_yb;
                    zb_reg   <= s_zb;
                    ta_reg   <= s_type_a;
                    tb_reg   <= s_type_b;
                    rbin_reg <= s_read_bin;
                end
            end
            F_DIFF: begin
                dx_reg   <= min_img(xa_reg, xb_reg, cfg.box_len_x);
                dy_reg   <= min_img(ya_reg, yb_reg, cfg.box_len_y);
                dz_reg   <= min_img(za_reg, zb_reg, cfg.box_len_z);
                r2_reg   <= '0;
                step_reg <= '0;
            end
            F_SQ: begin
                prod_reg <= SQ_W'(mag) * SQ_W'(mag);
                if (step_reg != '0) begin
                    r2_reg <= r2_reg + R2_W'(prod_reg);
                end
                if (step_reg == STEP_W'(SQ_STEPS)) begin
                    step_reg <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            F_ROOT: begin
                if (rem_shift >= trial) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                r2_reg   <= r2_reg << 2;
                step_reg <= step_reg + STEP_W'(1);
            end
            F_SCALE: begin
                bin_reg <= scaled[PROD_W-1:FRAC_W];
            end
            default: begin
            end
        endcase
    end

    // classification: species pair cell and bin range
    always_comb begin
        if (cfg.num_species == 3'd0) begin
            eff_s = SP_W'(1);
        end else if (SP_W'(cfg.num_species) > SP_W'(MAX_SPECIES)) begin
            eff_s = SP_W'(MAX_SPECIES);
        end else begin
            eff_s = SP_W'(cfg.num_species);
        end
        if (cfg.num_bins == 9'd0) begin
            eff_b = CMP_W'(1);
        end else if (CMP_W'(cfg.num_bins) > CMP_W'(MAX_BINS)) begin
            eff_b = CMP_W'(MAX_BINS);
        end else begin
            eff_b = CMP_W'(cfg.num_bins);
        end
        lo       = (ta_reg < tb_reg) ? ta_reg : tb_reg;
        hi       = (ta_reg < tb_reg) ? tb_reg : ta_reg;
        tri_n    = (8'(lo) * (8'(lo) - ((lo != 2'd0) ? 8'd1 : 8'd0))) >> 1;
        pair     = 8'(lo) * 8'(eff_s - SP_W'(1)) - tri_n + 8'(hi);
        type_ok  = (SP_W'(hi) < eff_s) && (32'(pair) < 32'(MAX_SPECIES * (MAX_SPECIES + 1) / 2));
        idx_wide = (op_reg == OP_ACC) ? CMP_W'(bin_reg) : CMP_W'(rbin_reg);
        bin_ok   = idx_wide < eff_b;
    end

    // command to the back
    always_comb begin
        q_cmd.op        = op_reg;
        q_cmd.ok        = type_ok && bin_ok &&
                          ((op_reg == OP_ACC) || (op_reg == OP_READ));
        q_cmd.bin_index = 8'd0;
        case (op_reg)
            OP_ACC: begin
                if ((q_cmd.ok) || (bin_reg <= BIN_W'(255))) begin
                    q_cmd.bin_index = bin_reg[7:0];
                end else begin
                    q_cmd.bin_index = 8'hFF;
                end
            end
            OP_READ: q_cmd.bin_index = rbin_reg;
            default: q_cmd.bin_index = 8'd0;
        endcase
        q_addr = AW'(AW'(pair) * AW'(MAX_BINS)) + AW'(idx_wide[BW-1:0]);
    end

endmodule

>>> design/pdh_back.sv
// ----------------------------------------------------------------------------
// pdh_back
// Histogram store with read-modify-write, frame counter, clearing sweep
// and the result register.
// ----------------------------------------------------------------------------
module pdh_back #(
    parameter int CELLS = 2560,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  pdh_pkg::cmd_t q_cmd,
    input  logic [AW-1:0] q_addr,
    output logic          clearing,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_hit,
    output logic [7:0]    m_bin_index,
    output logic [31:0]   m_bin_count,
    output logic [31:0]   m_frames
);
    import pdh_pkg::*;

    logic [CNT_W-1:0] mem [CELLS];

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg;
    logic [AW-1:0]    addr_reg, clr_reg;
    logic [CNT_W-1:0] rdata_reg, frames_reg, frames_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg;
    logic [7:0]       m_bin_index_reg;
    logic [CNT_W-1:0] m_bin_count_reg, m_frames_reg;

    logic             out_free, pop, out_load;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [CNT_W-1:0] wdata, incr;
    logic             o_hit;
    logic [7:0]       o_idx;
    logic [CNT_W-1:0] o_cnt, o_frames;

    assign out_free = !m_valid_reg || m_ready;
    assign incr     = (rdata_reg == SAT32) ? rdata_reg : rdata_reg + CNT_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR: begin
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid && out_free) begin
                    if (q_cmd.op == OP_CLEAR) begin
                        state_next = B_CLEAR;
                    end else if (q_cmd.ok) begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_ready     = (state_reg == B_IDLE) && out_free;
        pop         = q_ready && q_valid;
        clearing    = (state_reg == B_CLEAR);
        we          = 1'b0;
        waddr       = addr_reg;
        wdata       = incr;
        out_load    = 1'b0;
        o_hit       = 1'b0;
        o_idx       = 8'd0;
        o_cnt       = '0;
        o_frames    = frames_reg;
        frames_next = frames_reg;
        unique case (state_reg)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            B_IDLE: begin
                if (pop) begin
                    o_idx = q_cmd.bin_index;
                    case (q_cmd.op)
                        OP_FRAME: begin
                            out_load    = 1'b1;
                            frames_next = (frames_reg == SAT32) ? frames_reg
                                                                : frames_reg + CNT_W'(1);
                            o_frames    = frames_next;
                        end
                        OP_CLEAR: begin
                            out_load    = 1'b1;
                            frames_next = '0;
                            o_frames    = '0;
                        end
                        default: begin
                            out_load = !q_cmd.ok;
                        end
                    endcase
                end
            end
            B_READ: begin
                out_load = 1'b1;
                o_idx    = cmd_reg.bin_index;
                if (cmd_reg.op == OP_ACC) begin
                    we    = 1'b1;
                    o_hit = 1'b1;
                    o_cnt = incr;
                end else begin
                    o_cnt = rdata_reg;
                end
            end
            default: begin
            end
        endcase
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            frames_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            frames_reg  <= frames_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end else begin
                clr_reg <= '0;
            end
        end
    end

    // command latch and result register
    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg  <= q_cmd;
            addr_reg <= q_addr;
        end
        if (out_load) begin
            m_hit_reg       <= o_hit;
            m_bin_index_reg <= o_idx;
            m_bin_count_reg <= o_cnt;
            m_frames_reg    <= o_frames;
        end
    end

    // histogram memory
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[q_addr];
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_bin_count = m_bin_count_reg;
    assign m_frames    = m_frames_reg;

endmodule

>>> design/pair_distance_histogram.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram
// Radial distribution histogram: per atom pair, minimum-image distance,
// integer square root, bin scaling and a saturating count per species pair.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | op, positions, types, read_bin
//  m_      | out       | m_valid / m_ready    | hit, bin_index, bin_count, frames
//  cfg_    | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
//  accumulate: the front steps through accept, diff, 4 square steps, 25 root
//  steps, scale and push; the one-bit-per-cycle root loop sets the rate.
//  other ops go from accept straight to push; the back takes each item in its
//  idle state, and an accepted pair or read also in its read state. reset and
//  the clear op start a sweep of one histogram cell per cycle over all
//  MAX_SPECIES*(MAX_SPECIES+1)/2*MAX_BINS cells, 2560 by default; no item is
//  accepted during it. a two-entry queue and the result register let front and back stall independently.
// ----------------------------------------------------------------------------
module pair_distance_histogram #(
    parameter int MAX_SPECIES = 4,
    parameter int MAX_BINS    = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [23:0] s_xa,
    input  logic signed [23:0] s_ya,
    input  logic signed [23:0] s_za,
    input  logic signed [23:0] s_xb,
    input  logic signed [23:0] s_yb,
    input  logic signed [23:0] s_zb,
    input  logic [1:0]         s_type_a,
    input  logic [1:0]         s_type_b,
    input  logic [7:0]         s_read_bin,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [7:0]         m_bin_index,
    output logic [31:0]        m_bin_count,
    output logic [31:0]        m_frames,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_wdata
);
    import pdh_pkg::*;

    localparam int NPAIR = MAX_SPECIES * (MAX_SPECIES + 1) / 2;
    localparam int CELLS = NPAIR * MAX_BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int QW    = $bits(cmd_t) + AW;

    cfg_t          cfg_reg;
    logic          clearing;
    logic          fq_valid, fq_ready, bq_valid, bq_ready;
    cmd_t          fq_cmd, bq_cmd;
    logic [AW-1:0] fq_addr, bq_addr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_len_x     <= BOX_W'(8388607);
            cfg_reg.box_len_y     <= BOX_W'(8388607);
            cfg_reg.box_len_z     <= BOX_W'(8388607);
            cfg_reg.inv_bin_width <= IBW_W'(65536);
            cfg_reg.num_bins      <= 9'd256;
            cfg_reg.num_species   <= 3'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BOX_X:    cfg_reg.box_len_x     <= cfg_wdata[BOX_W-1:0];
                CFG_BOX_Y:    cfg_reg.box_len_y     <= cfg_wdata[BOX_W-1:0];
                CFG_BOX_Z:    cfg_reg.box_len_z     <= cfg_wdata[BOX_W-1:0];
                CFG_INV_BW:   cfg_reg.inv_bin_width <= cfg_wdata;
                CFG_NUM_BINS: cfg_reg.num_bins      <= cfg_wdata[8:0];
                CFG_NUM_SPEC: cfg_reg.num_species   <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // front: distance, root, bin, classification
    pdh_front #(
        .MAX_SPECIES (MAX_SPECIES),
        .MAX_BINS    (MAX_BINS),
        .AW          (AW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .hold       (clearing),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (op_t'(s_op)),
        .s_xa       (s_xa),
        .s_ya       (s_ya),
        .s_za       (s_za),
        .s_xb       (s_xb),
        .s_yb       (s_yb),
        .s_zb       (s_zb),
        .s_type_a   (s_type_a),
        .s_type_b   (s_type_b),
        .s_read_bin (s_read_bin),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_cmd      (fq_cmd),
        .q_addr     (fq_addr)
    );

    // queue between front and back
    pdh_fifo #(
        .W (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_cmd, fq_addr}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  ({bq_cmd, bq_addr})
    );

    // back: histogram store and results
    pdh_back #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (bq_valid),
        .q_ready     (bq_ready),
        .q_cmd       (bq_cmd),
        .q_addr      (bq_addr),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_bin_index (m_bin_index),
        .m_bin_count (m_bin_count),
        .m_frames    (m_frames)
    );

    // no item enters while the store is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("item accepted during clearing sweep");

    // a counted pair always reports a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_bin_count != 32'd0))
        else $error("hit result with zero count");

    // the back never pops a command while a result is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bq_valid && bq_ready) |-> (!m_valid || m_ready))
        else $error("command popped while result register full");

endmodule

>>> tb/pair_distance_histogram_tb.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram_tb
// Drives pair, frame, read and clear items through the histogram block under
// several box, bin and species settings, predicts every result with a local
// model of the histogram and checks results in order, field by field.
// ----------------------------------------------------------------------------
module pair_distance_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdh_pkg::*;

    localparam int NSPEC  = 4;
    localparam int NBINS  = 256;
    localparam int NPAIRS = NSPEC * (NSPEC + 1) / 2;
    localparam longint LIMIT = 3_000_000;

    typedef struct packed {
        logic        hit;
        logic [7:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] frames;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = '0;
    logic signed [23:0] s_xa = '0, s_ya = '0, s_za = '0;
    logic signed [23:0] s_xb = '0, s_yb = '0, s_zb = '0;
    logic [1:0] s_type_a = '0, s_type_b = '0;
    logic [7:0] s_read_bin = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [7:0] m_bin_index;
    logic [31:0] m_bin_count, m_frames;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    // predictor state
    logic [22:0] box_x, box_y, box_z;
    logic [23:0] inv_bw;
    logic [8:0] bins_reg;
    logic [2:0] spec_reg;
    logic [31:0] cells [NPAIRS*NBINS];
    logic [31:0] frame_cnt;

    outcome_t pending_results [$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;
    int gap_max = 3;

    pair_distance_histogram uut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint fold_axis(longint d, logic [22:0] len);
        longint l;
        l = len;
        if (2 * d > l) return d - l;
        if (2 * d < -l) return d + l;
        return d;
    endfunction

    function automatic longint floor_root(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967296;
        // largest lo with lo*lo <= v
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic int species_used();
        int s;
        s = spec_reg;
        if (s < 1) s = 1;
        if (s > NSPEC) s = NSPEC;
        return s;
    endfunction

    function automatic int bins_used();
        int b;
        b = bins_reg;
        if (b < 1) b = 1;
        if (b > NBINS) b = NBINS;
        return b;
    endfunction

    // cell row of an unordered species pair, -1 when out of range
    function automatic int pair_row(logic [1:0] ta, logic [1:0] tb);
        int s, lo, hi, p;
        s = species_used();
        lo = (ta < tb) ? ta : tb;
        hi = (ta < tb) ? tb : ta;
        if (hi >= s) return -1;
        p = (lo == 0) ? hi : lo * (s - 1) - (lo * (lo - 1)) / 2 + hi;
        return (p < NPAIRS) ? p : -1;
    endfunction

    function automatic outcome_t histogram_step(op_t op,
            logic signed [23:0] xa, ya, za, xb, yb, zb,
            logic [1:0] ta, tb, logic [7:0] rbin);
        outcome_t o;
        longint dx, dy, dz;
        longint unsigned r2, r, bin;
        int row;
        o = '0;
        case (op)
            OP_ACC: begin
                dx = fold_axis(longint'(xa) - longint'(xb), box_x);
                dy = fold_axis(longint'(ya) - longint'(yb), box_y);
                dz = fold_axis(longint'(za) - longint'(zb), box_z);
                r2 = dx * dx + dy * dy + dz * dz;
                r = floor_root(r2);
                bin = (r * inv_bw) >> 16;
                row = pair_row(ta, tb);
                if (bin < bins_used() && row >= 0) begin
                    if (cells[row*NBINS + bin] != SAT32)
                        cells[row*NBINS + bin] += 1;
                    o.hit = 1'b1;
                    o.bin_index = bin[7:0];
                    o.bin_count = cells[row*NBINS + bin];
                end else begin
                    o.bin_index = (bin > 255) ? 8'hFF : bin[7:0];
                end
            end
            OP_FRAME: begin
                if (frame_cnt != SAT32) frame_cnt += 1;
            end
            OP_READ: begin
                o.bin_index = rbin;
                row = pair_row(ta, tb);
                if (rbin < bins_used() && row >= 0)
                    o.bin_count = cells[row*NBINS + rbin];
            end
            default: begin
                foreach (cells[i]) cells[i] = '0;
                frame_cnt = '0;
            end
        endcase
        o.frames = frame_cnt;
        return o;
    endfunction

    // result checker
    always @(posedge aclk) begin
        outcome_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_hit, m_bin_index, m_bin_count, m_frames};
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else if (cycles % 64 < 20) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(op_t op, logic signed [23:0] xa, ya, za, xb, yb, zb,
            logic [1:0] ta, tb, logic [7:0] rbin);
        s_valid <= 1'b1;
        s_op <= op;
        s_xa <= xa; s_ya <= ya; s_za <= za;
        s_xb <= xb; s_yb <= yb; s_zb <= zb;
        s_type_a <= ta; s_type_b <= tb; s_read_bin <= rbin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(histogram_step(op, xa, ya, za, xb, yb, zb, ta, tb, rbin));
        // bursts with random gaps
        if (gap_max > 0 && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_BOX_X:    box_x = val[22:0];
            CFG_BOX_Y:    box_y = val[22:0];
            CFG_BOX_Z:    box_z = val[22:0];
            CFG_INV_BW:   inv_bw = val;
            CFG_NUM_BINS: bins_reg = val[8:0];
            CFG_NUM_SPEC: spec_reg = val[2:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [22:0] bx, by, bz, logic [23:0] ibw,
            logic [8:0] nb, logic [2:0] ns);
        write_reg(CFG_BOX_X, bx);
        write_reg(CFG_BOX_Y, by);
        write_reg(CFG_BOX_Z, bz);
        write_reg(CFG_INV_BW, ibw);
        write_reg(CFG_NUM_BINS, nb);
        write_reg(CFG_NUM_SPEC, ns);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_pos(int span);
        if (span <= 0) return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // random pairs near one another so most land in range
    task automatic random_pair(int span);
        logic signed [23:0] xa, ya, za;
        xa = $urandom; ya = $urandom; za = $urandom;
        send_item(OP_ACC, xa, ya, za, xa + rand_pos(span), ya + rand_pos(span),
                  za + rand_pos(span), $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        logic signed [23:0] mx, mn;
        mx = 24'sh7FFFFF;
        mn = -24'sh800000;
        setup(23'd100, 23'd100, 23'd100, 24'd65536, 9'd256, 3'd4);
        send_item(OP_ACC, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_ACC, 3, 4, 0, 0, 0, 0, 1, 3, 0);
        send_item(OP_ACC, 0, 0, 0, 3, 4, 0, 3, 1, 0);
        send_item(OP_ACC, 60, 0, 0, 0, 0, 0, 2, 2, 0);
        send_item(OP_ACC, -60, 0, 0, 0, 0, 0, 0, 3, 0);
        send_item(OP_ACC, 50, 50, 50, 0, 0, 0, 3, 3, 0);
        send_item(OP_ACC, mx, mx, mx, mn, mn, mn, 0, 0, 0);
        send_item(OP_ACC, mn, mn, mn, mx, mx, mx, 1, 1, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 3, 1, 5);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 255);
        send_item(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        setup(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'd1, 9'd1, 3'd1);
        send_item(OP_ACC, mx, mx, mx, mn, mn, mn, 0, 0, 0);
        send_item(OP_ACC, 5, 5, 5, 0, 0, 0, 0, 1, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        drain();
        // out of range register values: zero box, zero scale, zero and huge counts
        setup(23'd0, 23'd0, 23'd0, 24'd0, 9'd0, 3'd7);
        send_item(OP_ACC, mx, 0, 0, mn, 0, 0, 0, 0, 0);
        send_item(OP_ACC, 1, 1, 1, 0, 0, 0, 3, 2, 0);
        drain();
        setup(23'd1, 23'd1, 23'd1, 24'hFFFFFF, 9'd511, 3'd0);
        send_item(OP_ACC, 1, 2, 3, 0, 0, 0, 0, 0, 0);
        send_item(OP_ACC, 100, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random(int count, int span);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 75) random_pair(span);
            else if (k < 80) send_item(OP_ACC, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, 0);
            else if (k < 94) send_item(OP_READ, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (k < 99) send_item(OP_FRAME, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        drain();
    endtask

    task automatic test_settings();
        setup(23'd2000, 23'd3000, 23'd1500, 24'd65536 * 4, 9'd200, 3'd4);
        test_random(400, 300);
        setup($urandom_range(1, 8388607), $urandom_range(1, 8388607),
              $urandom_range(1, 8388607), 24'd16, 9'd256, 3'd3);
        test_random(400, 0);
        gap_max = 0;
        setup(23'd50, 23'd70, 23'd90, 24'd65536 * 3, 9'd64, 3'd2);
        test_random(400, 60);
        gap_max = 4;
        setup(23'h7FFFFF, 23'd1000, 23'd1, 24'd200000, 9'd16, 3'd4);
        test_random(400, 20);
    endtask

    // long receiver hold-off while items keep coming
    task automatic test_backpressure();
        gap_max = 0;
        setup(23'd1000, 23'd1000, 23'd1000, 24'd65536, 9'd256, 3'd4);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++) begin
                    if (i % 2 == 0) random_pair(50);
                    else send_item(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                end
            end
        join
        drain();
    endtask

    initial begin
        box_x = 23'h7FFFFF; box_y = 23'h7FFFFF; box_z = 23'h7FFFFF;
        inv_bw = 24'd65536; bins_reg = 9'd256; spec_reg = 3'd1;
        foreach (cells[i]) cells[i] = '0;
        frame_cnt = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_settings();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
